@@ rtl/c8x_pkg.sv @@
// Package with shared constants and the font glyph table of the CHIP-8 executor.
`timescale 1ns / 1ps
package c8x_pkg;
  localparam int unsigned RamDepthDefault = 4096;
  localparam int unsigned StackDepthDefault = 16;
  localparam int unsigned FontBytes = 80;
  localparam logic [11:0] ProgBase = 12'h200;

  localparam logic [1:0] OpLoad = 2'd0;
  localparam logic [1:0] OpStep = 2'd1;
  localparam logic [1:0] OpTick = 2'd2;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatIllegal = 2'd1;
  localparam logic [1:0] StatOutside = 2'd2;

  function automatic logic [7:0] font_byte(input logic [6:0] a);
    logic [7:0] g [0:79];
    g = '{8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
          8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
          8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
          8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
          8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
          8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
          8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
          8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80};
    if (a < 7'(FontBytes)) return g[a];
    return 8'h00;
  endfunction
endpackage

@@ rtl/c8x_ram.sv @@
// Generic single-port-write, single-read RAM with a registered read.
`timescale 1ns / 1ps
module c8x_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/chip8_instruction_executor.sv @@
// Top level of the CHIP-8 instruction executor: control, registers and memories.
`timescale 1ns / 1ps
//  channel | direction | handshake       | word
//  in      | input     | valid / ready   | operation, address, data, random_byte
//  out     | output    | out_valid/ready | status, instruction, program_counter,
//          |           |                 | index_value, x_value, y_value, ...
//
// A load or tick word goes straight to the result. A plain step runs two RAM reads for
// the fetch, two register file reads, the execute state, a read of VX and VY back
// after the update, and the state that shows the result. An ALU op that sets VF adds
// the flag write, a return the stack read, a jump by V0 the read of V0, BCD store one
// write per digit, and the block save and load a read and a write per register, set
// by the single RAM port. After reset a clearing pass over every RAM address writes
// the font glyphs and zeros into RAM and the register file; ready stays low during it.
// RAM_DEPTH must be a power of two; the block does not enforce it. The result sits in
// an output register; the next word is taken only after it left, and it waits for out_ready.
module chip8_instruction_executor #(
  parameter int unsigned RAM_DEPTH = c8x_pkg::RamDepthDefault,
  parameter int unsigned STACK_DEPTH = c8x_pkg::StackDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [1:0]  operation,
  input  logic [11:0] address,
  input  logic [7:0]  data,
  input  logic [7:0]  random_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] instruction,
  output logic [11:0] program_counter,
  output logic [15:0] index_value,
  output logic [7:0]  x_value,
  output logic [7:0]  y_value,
  output logic [7:0]  delay_value,
  output logic        sound_on
);
  import c8x_pkg::*;

  localparam int unsigned AW = $clog2(RAM_DEPTH);
  localparam int unsigned SW = $clog2(STACK_DEPTH);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FETCH_HI, S_FETCH_LO, S_RD_X, S_RD_Y, S_EXEC,
    S_BCD, S_SAVE_RD, S_SAVE_WR, S_LOAD_RD, S_LOAD_WR, S_RET, S_OUT
  } state_t;

  state_t state;
  state_t exec_next;

  // RAM port signals.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  // Register file port signals.
  logic          rf_we;
  logic [3:0]    rf_waddr, rf_raddr;
  logic [7:0]    rf_wdata, rf_rdata;
  logic [7:0]    rf_rdata_x;
  // Stack port signals.
  logic          stk_we;
  logic [SW-1:0] stk_addr_w, stk_addr_r;
  logic [11:0]   stk_wdata, stk_rdata;

  logic [AW:0]   clr_cnt;
  logic [11:0]   pc;
  logic [SW-1:0] sp;
  logic [15:0]   index_reg;
  logic [7:0]    delay_timer, sound_timer;
  logic [15:0]   word;
  logic [7:0]    vx, vy, rnd;
  logic [4:0]    k;
  logic [1:0]    bcd_step;
  logic [7:0]    hi_byte;

  c8x_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata));
  c8x_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
    .clk, .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_rdata));
  c8x_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
    .clk, .we(stk_we), .waddr(stk_addr_w), .wdata(stk_wdata),
    .raddr(stk_addr_r), .rdata(stk_rdata));

  assign ready = (state == S_IDLE);
  assign sound_on = (sound_timer != 8'd0);
  assign delay_value = delay_timer;
  assign program_counter = pc;
  assign index_value = index_reg;

  wire [3:0]  wx = word[11:8];
  wire [3:0]  wy = word[7:4];
  wire [7:0]  nn = word[7:0];
  wire [11:0] nnn = word[11:0];
  wire [11:0] pc_plus2 = pc + 12'd2;

  // The stack pointer wraps at the stack depth in both directions.
  wire [SW-1:0] sp_dec = (sp == '0) ? SW'(STACK_DEPTH - 1) : SW'(sp - SW'(1));
  wire [SW-1:0] sp_inc = (sp == SW'(STACK_DEPTH - 1)) ? '0 : SW'(sp + SW'(1));

  // BCD digits of vx: hundreds by compare, tens by a small reciprocal.
  logic [1:0] bcd_h;
  logic [6:0] bcd_r;
  logic [3:0] bcd_t, bcd_o;
  always_comb begin
    bcd_h = (vx >= 8'd200) ? 2'd2 : (vx >= 8'd100) ? 2'd1 : 2'd0;
    bcd_r = 7'(vx - 8'(bcd_h) * 8'd100);
    bcd_t = 4'((15'(bcd_r) * 15'd205) >> 11);
    bcd_o = 4'(bcd_r - 7'(bcd_t) * 7'd10);
  end

  wire [AW-1:0] idx_k = AW'(index_reg + 16'(k));
  wire [AW-1:0] fetch_a = AW'(17'(ProgBase) + 17'(pc));

  // State that follows the execute cycle; most words go straight to the result.
  always_comb begin
    exec_next = S_OUT;
    case (word[15:12])
      4'h0: if (nnn == 12'h0EE) exec_next = S_LOAD_WR;
      4'h8: if (word[3:0] inside {4'h4, 4'h5, 4'h6, 4'h7, 4'hE}) exec_next = S_RET;
      4'hB: exec_next = S_SAVE_RD; // register V0 read first
      4'hF: begin
        case (nn)
          8'h33: exec_next = S_BCD;
          8'h55: exec_next = S_SAVE_RD;
          8'h65: exec_next = S_LOAD_RD;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Memory port control.
  always_comb begin
    ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0; ram_raddr = fetch_a;
    rf_we = 1'b0; rf_waddr = '0; rf_wdata = '0; rf_raddr = wx;
    stk_we = 1'b0; stk_addr_w = sp; stk_wdata = pc;
    stk_addr_r = sp_dec;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_cnt[AW-1:0];
        ram_wdata = (clr_cnt < (AW+1)'(FontBytes)) ? font_byte(clr_cnt[6:0]) : 8'h00;
        rf_we = 1'b1;
        rf_waddr = clr_cnt[3:0];
      end
      S_IDLE: begin
        ram_we = valid && operation == OpLoad;
        ram_waddr = AW'(address);
        ram_wdata = data;
      end
      S_FETCH_HI: ram_raddr = AW'(17'(ProgBase) + 17'(pc) + 17'd1);
      S_RD_Y: rf_raddr = wy;
      S_SAVE_RD: rf_raddr = k[3:0];
      S_SAVE_WR: begin
        // A jump by V0 only reads the register and leaves RAM alone.
        ram_we = (word[15:12] != 4'hB); ram_waddr = idx_k; ram_wdata = rf_rdata;
      end
      S_LOAD_RD: ram_raddr = idx_k;
      S_LOAD_WR: begin
        // A return passes through here only to pick up the stack entry.
        rf_we = (k != 5'd31); rf_waddr = k[3:0]; rf_wdata = ram_rdata;
      end
      S_BCD: begin
        ram_we = 1'b1; ram_waddr = idx_k;
        case (bcd_step)
          2'd0: ram_wdata = 8'(bcd_h);
          2'd1: ram_wdata = 8'(bcd_t);
          default: ram_wdata = 8'(bcd_o);
        endcase
      end
      S_EXEC: begin
        // VY arrives from the register file in this cycle.
        rf_waddr = wx;
        case (word[15:12])
          4'h6: begin rf_we = 1'b1; rf_wdata = nn; end
          4'h7: begin rf_we = 1'b1; rf_wdata = vx + nn; end
          4'hC: begin rf_we = 1'b1; rf_wdata = rnd & nn; end
          4'h8: begin
            rf_we = 1'b1;
            case (word[3:0])
              4'h0: rf_wdata = rf_rdata;
              4'h1: rf_wdata = vx | rf_rdata;
              4'h2: rf_wdata = vx & rf_rdata;
              4'h3: rf_wdata = vx ^ rf_rdata;
              4'h4: rf_wdata = vx + rf_rdata;
              4'h5: rf_wdata = vx - rf_rdata;
              4'h7: rf_wdata = rf_rdata - vx;
              4'h6: rf_wdata = vx >> 1;
              4'hE: rf_wdata = vx << 1;
              default: rf_we = 1'b0;
            endcase
          end
          4'hF: if (nn == 8'h07) begin rf_we = 1'b1; rf_wdata = delay_timer; end
          4'h2: stk_we = 1'b1;
          default: ;
        endcase
      end
      S_RET: begin
        // Flag write for ALU ops that set VF, after the result write.
        rf_we = 1'b1; rf_waddr = 4'hF;
        case (word[3:0])
          4'h4: rf_wdata = 8'(({1'b0, vx} + {1'b0, vy}) > 9'h0FF);
          4'h5: rf_wdata = 8'(vx >= vy);
          4'h7: rf_wdata = 8'(vy >= vx);
          4'h6: rf_wdata = 8'(vx[0]);
          default: rf_wdata = 8'(vx[7]);
        endcase
        rf_raddr = wx;
      end
      S_OUT: rf_raddr = wy;
      default: ;
    endcase
  end

  logic out_yphase;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr_cnt <= '0; pc <= '0; sp <= '0; index_reg <= '0;
      delay_timer <= '0; sound_timer <= '0; out_valid <= 1'b0; out_yphase <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(RAM_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: if (valid) begin
          word <= '0; rnd <= random_byte; status <= StatOk;
          instruction <= '0; x_value <= '0; y_value <= '0;
          if (operation == OpStep) state <= S_FETCH_HI;
          else begin
            if (operation == OpTick) begin
              if (delay_timer != 8'd0) delay_timer <= delay_timer - 8'd1;
              if (sound_timer != 8'd0) sound_timer <= sound_timer - 8'd1;
            end
            out_valid <= 1'b1;
            state <= S_OUT;
            out_yphase <= 1'b1;
          end
        end
        S_FETCH_HI: begin hi_byte <= ram_rdata; state <= S_FETCH_LO; end
        S_FETCH_LO: begin
          word <= {hi_byte, ram_rdata}; pc <= pc_plus2; state <= S_RD_X;
        end
        S_RD_X: state <= S_RD_Y;
        S_RD_Y: begin vx <= rf_rdata; state <= S_EXEC; end
        S_EXEC: begin
          vy <= rf_rdata;
          state <= exec_next;
          k <= (exec_next == S_LOAD_WR) ? 5'd31 : 5'd0;
          bcd_step <= '0;
          instruction <= word;
          out_yphase <= 1'b0;
          case (word[15:12])
            4'h0: begin
              if (nnn == 12'h0E0) status <= StatOutside;
              else if (nnn == 12'h0EE) sp <= sp_dec;
            end
            4'h1: pc <= nnn - ProgBase;
            4'h2: begin pc <= nnn - ProgBase; sp <= sp_inc; end
            4'h3: if (vx == nn) pc <= pc_plus2;
            4'h4: if (vx != nn) pc <= pc_plus2;
            4'h5: if (vx == rf_rdata) pc <= pc_plus2;
            4'h9: if (vx != rf_rdata) pc <= pc_plus2;
            4'h8: if (!(word[3:0] inside {[4'h0:4'h7], 4'hE})) status <= StatIllegal;
            4'hA: index_reg <= 16'(nnn);
            4'hD: status <= StatOutside;
            4'hE: status <= (nn == 8'h9E || nn == 8'hA1) ? StatOutside : StatIllegal;
            4'hF: case (nn)
              8'h07: ;
              8'h15: delay_timer <= vx;
              8'h18: sound_timer <= vx;
              8'h1E: index_reg <= index_reg + 16'(vx);
              8'h0A: status <= StatOutside;
              8'h29: if (vx > 8'h0F) status <= StatIllegal;
                     else index_reg <= 16'(vx) * 16'd5;
              8'h33, 8'h55, 8'h65: ;
              default: status <= StatIllegal;
            endcase
            default: ;
          endcase
        end
        S_RET: state <= S_OUT;
        S_BCD: begin
          k <= k + 5'd1; bcd_step <= bcd_step + 2'd1;
          if (bcd_step == 2'd2) state <= S_OUT;
        end
        S_SAVE_RD: state <= S_SAVE_WR;
        S_SAVE_WR: begin
          if (word[15:12] == 4'hB) begin
            pc <= 12'(16'(rf_rdata) + 16'(nnn) - 16'(ProgBase));
            state <= S_OUT;
          end else begin
            k <= k + 5'd1;
            state <= (k[3:0] == wx) ? S_OUT : S_SAVE_RD;
          end
        end
        S_LOAD_RD: state <= S_LOAD_WR;
        S_LOAD_WR: begin
          if (k == 5'd31) begin
            // Return: stack entry read in the previous cycle.
            pc <= stk_rdata;
            state <= S_OUT;
          end else begin
            k <= k + 5'd1;
            state <= (k[3:0] == wx) ? S_OUT : S_LOAD_RD;
          end
        end
        S_OUT: begin
          // A step first reads VX and VY after the update; a load or tick shows at once.
          if (!out_yphase) begin
            out_yphase <= 1'b1;
          end else if (!out_valid) begin
            x_value <= rf_rdata_x;
            y_value <= rf_rdata;
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // X value is read through a second copy of the register file that takes the same writes.
  c8x_ram #(.WIDTH(8), .DEPTH(16)) u_regs_x (
    .clk, .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(wx), .rdata(rf_rdata_x));
endmodule
